### rtl/abkf_pkg.sv
// Shared types, codes and constants of the angle and gyro-bias Kalman filter.
// Holds the micro-program that the sequencer in the top level steps through.
// No dependencies.
package abkf_pkg;

  // Fixed-point and port geometry.
  localparam int FRAC_BITS    = 24;  // fraction bits of the covariance and gain format
  localparam int MUL_DIGIT    = 16;  // multiplier bits consumed per cycle
  localparam int NOISE_W      = 31;
  localparam int CFG_ADDR_W   = 4;
  localparam int NUM_CFG_REGS = 3;

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 31'd16777;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST  = 31'd50332;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST  = 31'd503316;

  localparam int STEP_W   = 5;
  localparam int PROG_LEN = 29;

  typedef enum logic [1:0] {
    CMD_UPDATE    = 2'd0,
    CMD_SET_ANGLE = 2'd1,
    CMD_REINIT    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ANGLE_NOISE = 2'd0,
    REG_BIAS_NOISE  = 2'd1,
    REG_MEAS_NOISE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  // Operand and destination selects of the shared unit.
  typedef enum logic [4:0] {
    R_ANGLE,
    R_BIAS,
    R_RATE,
    R_C00,
    R_C01,
    R_C10,
    R_C11,
    R_MA,
    R_MR,
    R_DT,
    R_QA,
    R_QB,
    R_MN,
    R_P,
    R_M,
    R_T,
    R_K0,
    R_K1
  } opnd_t;

  typedef enum logic [2:0] {
    AST_IDLE,
    AST_MUL,
    AST_DIV,
    AST_FIN,
    AST_DONE
  } alu_state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ISSUE,
    SEQ_WAIT,
    SEQ_LAST
  } seq_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    alu_op_t op;
    opnd_t   dst;
    opnd_t   src_a;
    opnd_t   src_b;
  } prog_step_t;

  function automatic prog_step_t mk_step(alu_op_t op, opnd_t dst, opnd_t a, opnd_t b);
    prog_step_t s;
    s.op    = op;
    s.dst   = dst;
    s.src_a = a;
    s.src_b = b;
    return s;
  endfunction

  // One predict and update pass. P, M, T, K0 and K1 are scratch registers:
  // T holds the innovation variance from step 13 on, M the innovation from
  // step 16 on. The covariance correction reads C00 and C01 before it
  // overwrites them, so no copies are needed.
  function automatic prog_step_t prog_at(logic [STEP_W-1:0] idx);
    prog_step_t s;
    case (idx)
      5'd0:    s = mk_step(OP_SUB, R_RATE,  R_MR,    R_BIAS);
      5'd1:    s = mk_step(OP_MUL, R_P,     R_DT,    R_RATE);
      5'd2:    s = mk_step(OP_ADD, R_ANGLE, R_ANGLE, R_P);
      5'd3:    s = mk_step(OP_MUL, R_M,     R_DT,    R_C11);
      5'd4:    s = mk_step(OP_SUB, R_T,     R_M,     R_C01);
      5'd5:    s = mk_step(OP_SUB, R_T,     R_T,     R_C10);
      5'd6:    s = mk_step(OP_ADD, R_T,     R_T,     R_QA);
      5'd7:    s = mk_step(OP_MUL, R_P,     R_DT,    R_T);
      5'd8:    s = mk_step(OP_ADD, R_C00,   R_C00,   R_P);
      5'd9:    s = mk_step(OP_SUB, R_C01,   R_C01,   R_M);
      5'd10:   s = mk_step(OP_SUB, R_C10,   R_C10,   R_M);
      5'd11:   s = mk_step(OP_MUL, R_P,     R_QB,    R_DT);
      5'd12:   s = mk_step(OP_ADD, R_C11,   R_C11,   R_P);
      5'd13:   s = mk_step(OP_ADD, R_T,     R_C00,   R_MN);
      5'd14:   s = mk_step(OP_DIV, R_K0,    R_C00,   R_T);
      5'd15:   s = mk_step(OP_DIV, R_K1,    R_C10,   R_T);
      5'd16:   s = mk_step(OP_SUB, R_M,     R_MA,    R_ANGLE);
      5'd17:   s = mk_step(OP_MUL, R_P,     R_K0,    R_M);
      5'd18:   s = mk_step(OP_ADD, R_ANGLE, R_ANGLE, R_P);
      5'd19:   s = mk_step(OP_MUL, R_P,     R_K1,    R_M);
      5'd20:   s = mk_step(OP_ADD, R_BIAS,  R_BIAS,  R_P);
      5'd21:   s = mk_step(OP_MUL, R_P,     R_K1,    R_C00);
      5'd22:   s = mk_step(OP_SUB, R_C10,   R_C10,   R_P);
      5'd23:   s = mk_step(OP_MUL, R_P,     R_K1,    R_C01);
      5'd24:   s = mk_step(OP_SUB, R_C11,   R_C11,   R_P);
      5'd25:   s = mk_step(OP_MUL, R_P,     R_K0,    R_C00);
      5'd26:   s = mk_step(OP_SUB, R_C00,   R_C00,   R_P);
      5'd27:   s = mk_step(OP_MUL, R_P,     R_K0,    R_C01);
      5'd28:   s = mk_step(OP_SUB, R_C01,   R_C01,   R_P);
      default: s = mk_step(OP_ADD, R_P,     R_P,     R_P);
    endcase
    return s;
  endfunction

endpackage

### rtl/abkf_alu.sv
// Shared arithmetic unit: saturating add and subtract, Q8.24 multiply and
// Q8.24 divide, each result saturated to the signed word range.
// Depends on abkf_pkg.
module abkf_alu #(
  parameter int WORD_WIDTH = 32,
  localparam int EW = (WORD_WIDTH > 32) ? WORD_WIDTH : 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  abkf_pkg::alu_cmd_t           cmd,
  input  logic signed [EW-1:0]         opa,
  input  logic signed [EW-1:0]         opb,
  output logic                         done,
  output logic signed [WORD_WIDTH-1:0] result
);
  import abkf_pkg::*;

  localparam int NCH = (EW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int PW  = NCH * MUL_DIGIT;
  localparam int AW  = EW + PW;
  localparam int MGW = AW - FRAC_BITS;
  localparam int NB  = WORD_WIDTH + FRAC_BITS;
  localparam int RW  = WORD_WIDTH + 1;
  localparam int QW  = WORD_WIDTH + 1;
  localparam int CW  = $clog2(NB + 1);
  localparam logic [MGW-1:0] LIM_POS = {{(MGW-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [MGW-1:0] LIM_NEG = LIM_POS + 1'b1;

  alu_state_t state, state_next;

  logic [CW-1:0]                cnt;
  logic                         neg;
  logic                         is_div;
  logic                         dz;
  logic                         ovf;
  logic [EW-1:0]                xa;
  logic [PW-1:0]                xb;
  logic [AW-1:0]                acc;
  logic [NB-1:0]                num;
  logic [WORD_WIDTH-1:0]        dv;
  logic [RW-1:0]                rem;
  logic [QW-1:0]                quo;

  logic [EW-1:0]                mag_a, mag_b;
  logic signed [EW:0]           ea, eb, sum_ext;
  logic [EW+MUL_DIGIT-1:0]      pp;
  logic [AW-1:0]                acc_step;
  logic [RW-1:0]                rs, rem_step;
  logic                         qbit;
  logic [MGW-1:0]               mag_fin, lim, sat_mag;
  logic [WORD_WIDTH-1:0]        sat_w;
  logic signed [WORD_WIDTH-1:0] fin_value;

  function automatic logic signed [WORD_WIDTH-1:0] sat_word(logic signed [EW:0] v);
    logic [EW-WORD_WIDTH+1:0] top;
    top = v[EW:WORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      return v[WORD_WIDTH-1:0];
    end else if (v[EW]) begin
      return {1'b1, {(WORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_WIDTH-1){1'b1}}};
    end
  endfunction

  always_comb begin
    mag_a   = opa[EW-1] ? (~opa + 1'b1) : opa;
    mag_b   = opb[EW-1] ? (~opb + 1'b1) : opb;
    ea      = (EW+1)'(opa);
    eb      = (EW+1)'(opb);
    sum_ext = (cmd.op == OP_SUB) ? (ea - eb) : (ea + eb);
  end

  // One digit of the multiplier per cycle, most significant digit first.
  assign pp       = xa * xb[PW-1 -: MUL_DIGIT];
  assign acc_step = (acc << MUL_DIGIT) + AW'(pp);

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rs       = {rem[RW-2:0], num[NB-1]};
    qbit     = (rs >= {1'b0, dv});
    rem_step = qbit ? (rs - {1'b0, dv}) : rs;
  end

  always_comb begin
    if (is_div) begin
      mag_fin = ovf ? {MGW{1'b1}} : MGW'(quo);
    end else begin
      mag_fin = acc[AW-1:FRAC_BITS];
    end
    lim       = neg ? LIM_NEG : LIM_POS;
    sat_mag   = (mag_fin > lim) ? lim : mag_fin;
    sat_w     = sat_mag[WORD_WIDTH-1:0];
    fin_value = (is_div && dz) ? '0 : (neg ? (~sat_w + 1'b1) : sat_w);
  end

  always_comb begin
    state_next = state;
    case (state)
      AST_IDLE: begin
        if (cmd.start) begin
          case (cmd.op)
            OP_MUL:  state_next = AST_MUL;
            OP_DIV:  state_next = AST_DIV;
            default: state_next = AST_DONE;
          endcase
        end
      end
      AST_MUL: begin
        if (cnt == CW'(NCH - 1)) state_next = AST_FIN;
      end
      AST_DIV: begin
        if (cnt == CW'(NB - 1)) state_next = AST_FIN;
      end
      AST_FIN:  state_next = AST_DONE;
      AST_DONE: state_next = AST_IDLE;
      default:  state_next = AST_IDLE;
    endcase
  end

  always_comb begin
    done = (state == AST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      AST_IDLE: begin
        if (cmd.start) begin
          cnt    <= '0;
          neg    <= opa[EW-1] ^ opb[EW-1];
          is_div <= (cmd.op == OP_DIV);
          dz     <= (mag_b == '0);
          ovf    <= 1'b0;
          xa     <= mag_a;
          xb     <= PW'(mag_b);
          acc    <= '0;
          num    <= {mag_a[WORD_WIDTH-1:0], {FRAC_BITS{1'b0}}};
          dv     <= mag_b[WORD_WIDTH-1:0];
          rem    <= '0;
          quo    <= '0;
          result <= sat_word(sum_ext);
        end
      end
      AST_MUL: begin
        acc <= acc_step;
        xb  <= xb << MUL_DIGIT;
        cnt <= cnt + 1'b1;
      end
      AST_DIV: begin
        rem <= rem_step;
        quo <= {quo[QW-2:0], qbit};
        ovf <= ovf | quo[QW-1];
        num <= num << 1;
        cnt <= cnt + 1'b1;
      end
      AST_FIN: begin
        result <= fin_value;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/angle_bias_kalman_filter.sv
// Top level of the two-state angle and gyro-bias Kalman filter.
// Depends on abkf_pkg and abkf_alu.
//
//   Channel   Direction  Handshake             Contents
//   input     in         in_valid / in_ready   command, measured_angle, measured_rate,
//                                              time_step, start_angle
//   result    out        out_valid / out_ready filtered_angle, unbiased_rate
//   config    in         APB psel / penable    noise registers at 0x0, 0x4, 0x8
//
// An update command runs 17 adds or subtracts, 10 multiplies and two divides on the shared
// unit, between the transfer cycle and the hand-over of the result. The two restoring
// divisions dominate. Set-angle, re-initialise and the unused command skip the
// micro-program and go from the transfer cycle straight to the result.
// Reset is synchronous; it loads the noise defaults and clears estimates and covariance.
// A stalled result does not block the next transfer; the next item then waits in its final
// state until the pending result has been transferred.
module angle_bias_kalman_filter #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic signed [31:0]                  measured_angle,
  input  logic signed [31:0]                  measured_rate,
  input  logic [30:0]                         time_step,
  input  logic signed [31:0]                  start_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  filtered_angle,
  output logic signed [31:0]                  unbiased_rate,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [abkf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import abkf_pkg::*;

  // Operands are wide enough for a state word and for a 31-bit noise register.
  localparam int EW = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;

  seq_state_t state, state_next;
  logic [STEP_W-1:0] step;
  prog_step_t        cur;

  // Filter state, kept as signed words.
  logic signed [WORD_WIDTH-1:0] angle, bias, rate;
  logic signed [WORD_WIDTH-1:0] c00, c01, c10, c11;
  // Noise registers.
  logic [NOISE_W-1:0] qa, qb, mn;
  // Latched inputs and scratch registers of the update pass.
  logic signed [WORD_WIDTH-1:0] ma, mr, dt;
  logic signed [WORD_WIDTH-1:0] p, m, t, k0, k1;

  logic                         in_xfer;
  logic                         cfg_wr;
  logic                         wb_en;
  logic                         out_load;
  alu_cmd_t                     alu_cmd;
  logic signed [EW-1:0]         opa, opb;
  logic                         alu_done;
  logic signed [WORD_WIDTH-1:0] alu_y;

  // Saturates an extended value to the signed word range.
  function automatic logic signed [WORD_WIDTH-1:0] sat_word(logic signed [EW:0] v);
    logic [EW-WORD_WIDTH+1:0] top;
    top = v[EW:WORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      return v[WORD_WIDTH-1:0];
    end else if (v[EW]) begin
      return {1'b1, {(WORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_WIDTH-1){1'b1}}};
    end
  endfunction

  // Saturates a state word to the 32-bit result format.
  function automatic logic signed [31:0] to_out(logic signed [WORD_WIDTH-1:0] x);
    logic signed [EW:0] v;
    logic [EW-31:0]     top;
    v   = (EW+1)'(x);
    top = v[EW:31];
    if ((&top) || !(|top)) begin
      return v[31:0];
    end else if (v[EW]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  assign in_xfer = in_valid && in_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign cur     = prog_at(step);

  // Register reads are combinational; the unused fourth slot reads as zero.
  always_comb begin
    case (paddr[CFG_ADDR_W-1:2])
      REG_ANGLE_NOISE: prdata = {1'b0, qa};
      REG_BIAS_NOISE:  prdata = {1'b0, qb};
      REG_MEAS_NOISE:  prdata = {1'b0, mn};
      default:         prdata = '0;
    endcase
  end

  // Operand selection for the shared unit. Words are sign-extended and the noise
  // registers zero-extended, so the unit always sees exact values.
  always_comb begin
    case (cur.src_a)
      R_ANGLE: opa = EW'(angle);
      R_BIAS:  opa = EW'(bias);
      R_RATE:  opa = EW'(rate);
      R_C00:   opa = EW'(c00);
      R_C01:   opa = EW'(c01);
      R_C10:   opa = EW'(c10);
      R_C11:   opa = EW'(c11);
      R_MA:    opa = EW'(ma);
      R_MR:    opa = EW'(mr);
      R_DT:    opa = EW'(dt);
      R_QA:    opa = EW'(qa);
      R_QB:    opa = EW'(qb);
      R_MN:    opa = EW'(mn);
      R_P:     opa = EW'(p);
      R_M:     opa = EW'(m);
      R_T:     opa = EW'(t);
      R_K0:    opa = EW'(k0);
      R_K1:    opa = EW'(k1);
      default: opa = '0;
    endcase
    case (cur.src_b)
      R_ANGLE: opb = EW'(angle);
      R_BIAS:  opb = EW'(bias);
      R_RATE:  opb = EW'(rate);
      R_C00:   opb = EW'(c00);
      R_C01:   opb = EW'(c01);
      R_C10:   opb = EW'(c10);
      R_C11:   opb = EW'(c11);
      R_MA:    opb = EW'(ma);
      R_MR:    opb = EW'(mr);
      R_DT:    opb = EW'(dt);
      R_QA:    opb = EW'(qa);
      R_QB:    opb = EW'(qb);
      R_MN:    opb = EW'(mn);
      R_P:     opb = EW'(p);
      R_M:     opb = EW'(m);
      R_T:     opb = EW'(t);
      R_K0:    opb = EW'(k0);
      R_K1:    opb = EW'(k1);
      default: opb = '0;
    endcase
  end

  abkf_alu #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .opa    (opa),
    .opb    (opb),
    .done   (alu_done),
    .result (alu_y)
  );

  // Sequencer: an update walks the micro-program one step at a time, issuing a step
  // and waiting for the shared unit before writing its result back. The other
  // commands change the state in the transfer cycle and go straight to the result.
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (in_valid) begin
          state_next = (command == CMD_UPDATE) ? SEQ_ISSUE : SEQ_LAST;
        end
      end
      SEQ_ISSUE: state_next = SEQ_WAIT;
      SEQ_WAIT: begin
        if (alu_done) begin
          state_next = (step == STEP_W'(PROG_LEN - 1)) ? SEQ_LAST : SEQ_ISSUE;
        end
      end
      SEQ_LAST: begin
        if (!out_valid || out_ready) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == SEQ_IDLE);
    alu_cmd.start = (state == SEQ_ISSUE);
    alu_cmd.op    = cur.op;
    wb_en         = (state == SEQ_WAIT) && alu_done;
    out_load      = (state == SEQ_LAST) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        step <= '0;
      end else if (wb_en) begin
        step <= step + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Filter state and noise registers. The user must write configuration only while the block
  // is idle, so that a write never meets a write-back; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      rate  <= '0;
      c00   <= '0;
      c01   <= '0;
      c10   <= '0;
      c11   <= '0;
      qa    <= ANGLE_NOISE_RST;
      qb    <= BIAS_NOISE_RST;
      mn    <= MEAS_NOISE_RST;
    end else begin
      if (cfg_wr) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_ANGLE_NOISE: qa <= pwdata[NOISE_W-1:0];
          REG_BIAS_NOISE:  qb <= pwdata[NOISE_W-1:0];
          REG_MEAS_NOISE:  mn <= pwdata[NOISE_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        // The rate of the last update is kept by both loading commands.
        case (command)
          CMD_SET_ANGLE: angle <= sat_word((EW+1)'(start_angle));
          CMD_REINIT: begin
            angle <= sat_word((EW+1)'(start_angle));
            bias  <= '0;
            c00   <= '0;
            c01   <= '0;
            c10   <= '0;
            c11   <= '0;
          end
          default: begin
          end
        endcase
      end
      if (wb_en) begin
        case (cur.dst)
          R_ANGLE: angle <= alu_y;
          R_BIAS:  bias  <= alu_y;
          R_RATE:  rate  <= alu_y;
          R_C00:   c00   <= alu_y;
          R_C01:   c01   <= alu_y;
          R_C10:   c10   <= alu_y;
          R_C11:   c11   <= alu_y;
          default: begin
          end
        endcase
      end
    end
  end

  // Latched inputs, scratch registers and the result register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ma <= sat_word((EW+1)'(measured_angle));
      mr <= sat_word((EW+1)'(measured_rate));
      dt <= sat_word((EW+1)'(time_step));
    end
    if (wb_en) begin
      case (cur.dst)
        R_P:  p  <= alu_y;
        R_M:  m  <= alu_y;
        R_T:  t  <= alu_y;
        R_K0: k0 <= alu_y;
        R_K1: k1 <= alu_y;
        default: begin
        end
      endcase
    end
    if (out_load) begin
      filtered_angle <= to_out(angle);
      unbiased_rate  <= to_out(rate);
    end
  end

endmodule

### rtl/abkf_checker.sv
// Port-level checks for the angle and gyro-bias Kalman filter, bound to its top level.
// Depends on abkf_pkg and angle_bias_kalman_filter.
module abkf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [31:0]              filtered_angle,
  input logic signed [31:0]              unbiased_rate,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [abkf_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [31:0]                     pwdata,
  input logic [31:0]                     prdata,
  input logic                            pready
);
  import abkf_pkg::*;

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  // A pending result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(filtered_angle) && $stable(unbiased_rate))
    else $error("pending result changed");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // Reset leaves the block ready with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("wrong state after reset");

  // A written noise register reads back what was written.
  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[CFG_ADDR_W-1:2] < NUM_CFG_REGS))
    |=> ((paddr == $past(paddr)) |-> (prdata == {1'b0, $past(pwdata[NOISE_W-1:0])})))
    else $error("register readback differs from the written value");

endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (.*);

### tb/angle_bias_kalman_filter_test.sv
// Self-checking testbench for angle_bias_kalman_filter: a fixed-point model of the tilt and
// gyro-bias filter predicts every result, and each result transfer is checked against it.
// Depends on abkf_pkg and the filter RTL only.
module angle_bias_kalman_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import abkf_pkg::*;

  // Rough figures for the run. The quiet limit lies far beyond the length of an update, so a
  // quiet spell that long can only mean the block has hung.
  localparam int STALL_PCT     = 15;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 300;

  // The command field is two bits wide; the fourth code is unused and must leave state alone.
  localparam logic [1:0]            CMD_UNUSED    = 2'd3;
  // Register index 3 is not mapped; a write there must change nothing.
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  localparam logic signed [31:0] ANGLE_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] ANGLE_MIN = 32'sh8000_0000;
  localparam logic [30:0]        DT_MAX    = 31'h7fff_ffff;
  localparam logic [30:0]        DT_1MS    = 31'd16777;

  typedef struct {
    logic [1:0]         command;
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic [30:0]        time_step;
    logic signed [31:0] start_angle;
  } tilt_item_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } tilt_result_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            command;
  logic signed [31:0]    measured_angle;
  logic signed [31:0]    measured_rate;
  logic [30:0]           time_step;
  logic signed [31:0]    start_angle;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [31:0]    filtered_angle;
  logic signed [31:0]    unbiased_rate;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  angle_bias_kalman_filter dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .measured_angle (measured_angle),
    .measured_rate  (measured_rate),
    .time_step      (time_step),
    .start_angle    (start_angle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_angle (filtered_angle),
    .unbiased_rate  (unbiased_rate),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------------------
  // Filter model. State words are held in 64-bit integers but never leave the signed 32-bit
  // range, so every product of two words fits before the Q8.24 scaling is dropped.
  // ---------------------------------------------------------------------------------------
  longint tilt_angle, tilt_bias, tilt_rate;
  longint cov00, cov01, cov10, cov11;
  longint q_angle, q_bias, r_meas;

  tilt_result_t results_due[$];

  int  mismatches = 0;
  bit  steady     = 1'b0;   // when set, neither side idles
  int  stall_left = 0;
  int  quiet      = 0;

  function automatic longint clip_word(longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clip_word(a + b);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    return clip_word(a - b);
  endfunction

  function automatic longint unsigned abs_word(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // A magnitude with its sign, saturated to the word; the negative side reaches one further.
  function automatic longint signed_limit(bit neg, longint unsigned mag);
    if (neg) begin
      if (mag > 64'd2147483648) mag = 64'd2147483648;
      return -longint'(mag);
    end
    if (mag > 64'd2147483647) mag = 64'd2147483647;
    return longint'(mag);
  endfunction

  // Q8.24 product: the low fraction bits are dropped from the magnitude, so it rounds toward zero.
  function automatic longint q24_mul(longint a, longint b);
    longint unsigned prod;
    prod = (abs_word(a) * abs_word(b)) >> FRAC_BITS;
    return signed_limit((a < 0) != (b < 0), prod);
  endfunction

  // Q8.24 quotient, rounded toward zero; a zero divisor yields a zero gain.
  function automatic longint q24_div(longint num, longint den);
    longint unsigned quot;
    if (den == 0) return 0;
    quot = (abs_word(num) << FRAC_BITS) / abs_word(den);
    return signed_limit((num < 0) != (den < 0), quot);
  endfunction

  function automatic void reset_tilt_model();
    q_angle    = longint'(ANGLE_NOISE_RST);
    q_bias     = longint'(BIAS_NOISE_RST);
    r_meas     = longint'(MEAS_NOISE_RST);
    tilt_angle = 0;
    tilt_bias  = 0;
    tilt_rate  = 0;
    cov00      = 0;
    cov01      = 0;
    cov10      = 0;
    cov11      = 0;
  endfunction

  function automatic void load_noise_register(cfg_reg_t idx, logic [31:0] value);
    case (idx)
      REG_ANGLE_NOISE: q_angle = longint'(value[30:0]);
      REG_BIAS_NOISE:  q_bias  = longint'(value[30:0]);
      REG_MEAS_NOISE:  r_meas  = longint'(value[30:0]);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] noise_register(cfg_reg_t idx);
    case (idx)
      REG_ANGLE_NOISE: return q_angle[31:0];
      REG_BIAS_NOISE:  return q_bias[31:0];
      default:         return r_meas[31:0];
    endcase
  endfunction

  // One predict pass on the angle and covariance, then the correction by the measured angle.
  function automatic void run_tilt_update(longint ma, longint mr, longint dt);
    longint m, t, s, k0, k1, y, old00, old01;
    tilt_rate  = sub_sat(mr, tilt_bias);
    tilt_angle = add_sat(tilt_angle, q24_mul(dt, tilt_rate));

    m     = q24_mul(dt, cov11);
    t     = sub_sat(m, cov01);
    t     = sub_sat(t, cov10);
    t     = add_sat(t, q_angle);
    cov00 = add_sat(cov00, q24_mul(dt, t));
    cov01 = sub_sat(cov01, m);
    cov10 = sub_sat(cov10, m);
    cov11 = add_sat(cov11, q24_mul(q_bias, dt));

    s  = add_sat(cov00, r_meas);
    k0 = q24_div(cov00, s);
    k1 = q24_div(cov10, s);

    y          = sub_sat(ma, tilt_angle);
    tilt_angle = add_sat(tilt_angle, q24_mul(k0, y));
    tilt_bias  = add_sat(tilt_bias, q24_mul(k1, y));

    old00 = cov00;
    old01 = cov01;
    cov00 = sub_sat(cov00, q24_mul(k0, old00));
    cov01 = sub_sat(cov01, q24_mul(k0, old01));
    cov10 = sub_sat(cov10, q24_mul(k1, old00));
    cov11 = sub_sat(cov11, q24_mul(k1, old01));
  endfunction

  // Advances the model by one accepted item and queues the result it must produce.
  function automatic void predict_tilt_output(tilt_item_t item);
    tilt_result_t due;
    case (item.command)
      CMD_UPDATE:    run_tilt_update(longint'(item.measured_angle),
                                     longint'(item.measured_rate),
                                     longint'({1'b0, item.time_step}));
      CMD_SET_ANGLE: tilt_angle = longint'(item.start_angle);
      CMD_REINIT: begin
        tilt_angle = longint'(item.start_angle);
        tilt_bias  = 0;
        cov00      = 0;
        cov01      = 0;
        cov10      = 0;
        cov11      = 0;
      end
      default: ;
    endcase
    due.angle = tilt_angle[31:0];
    due.rate  = tilt_rate[31:0];
    results_due.push_back(due);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Reporting and checking.
  // ---------------------------------------------------------------------------------------

  // Every mismatch prints one line and is counted.
  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Each result transfer is compared with the oldest outstanding prediction. Sampling at the
  // rising edge sees the values from before the edge, since the block updates with
  // nonblocking assignments.
  always @(posedge clk) begin : result_check
    tilt_result_t want;
    if (out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch("result with no item outstanding", filtered_angle, 32'h0);
      end else begin
        want = results_due.pop_front();
        if (filtered_angle !== want.angle)
          flag_mismatch("filtered_angle", filtered_angle, want.angle);
        if (unbiased_rate !== want.rate)
          flag_mismatch("unbiased_rate", unbiased_rate, want.rate);
      end
    end
  end

  // The result side stalls in about fifteen percent of cycles, with a rare long stall so
  // that a finished result is held back for a while.
  always @(negedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 1999) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(10, 150);
    end else begin
      out_ready <= ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // The watchdog counts cycles in which no transfer of any kind takes place.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. Inputs change on the falling edge only.
  // ---------------------------------------------------------------------------------------

  // Most items follow at once; some wait a few cycles, and a few wait long enough for the
  // gap to land anywhere within an update.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(20, 300);
    if (roll < STALL_PCT) return $urandom_range(1, 6);
    return 0;
  endfunction

  // Offers one item and returns once it has been transferred. Valid stays high from one
  // item to the next unless a gap is taken, so it is never dropped and raised in one step.
  task automatic send_item(tilt_item_t item);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    while (gap > 0) begin
      in_valid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    command        <= item.command;
    measured_angle <= item.measured_angle;
    measured_rate  <= item.measured_rate;
    time_step      <= item.time_step;
    start_angle    <= item.start_angle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tilt_output(item);
  endtask

  // Lowers valid and holds off until every outstanding result has been transferred, which
  // leaves the block idle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // One APB transfer: a setup cycle, then access cycles until pready.
  task automatic apb_access(bit is_write, logic [CFG_ADDR_W-1:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic verify_noise_register(cfg_reg_t idx);
    logic [31:0] readback;
    apb_access(1'b0, {idx, 2'b00}, 32'h0, readback);
    if (readback !== noise_register(idx))
      flag_mismatch("noise register readback", readback, noise_register(idx));
  endtask

  // Writes a noise register, keeps the model in step and reads the register back. The top
  // bit of the written word does not exist in the register.
  task automatic write_noise_register(cfg_reg_t idx, logic [31:0] value);
    logic [31:0] unused_rdata;
    apb_access(1'b1, {idx, 2'b00}, value, unused_rdata);
    load_noise_register(idx, value);
    verify_noise_register(idx);
  endtask

  function automatic logic signed [31:0] spread(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic tilt_item_t make_item(logic [1:0] cmd, logic signed [31:0] ma,
                                           logic signed [31:0] mr, logic [30:0] dt,
                                           logic signed [31:0] sa);
    tilt_item_t it;
    it.command        = cmd;
    it.measured_angle = ma;
    it.measured_rate  = mr;
    it.time_step      = dt;
    it.start_angle    = sa;
    return it;
  endfunction

  // Mostly plausible sensor updates, so the filter settles and the gains stay meaningful,
  // with some angle loads and re-initialisations, and a share of items with every field
  // random. Harsh items use full-range measurements and time steps to drive saturation.
  function automatic tilt_item_t random_tilt_item(bit harsh);
    tilt_item_t it;
    int         pick;
    pick              = $urandom_range(0, 99);
    it.command        = CMD_UPDATE;
    it.measured_angle = spread(90 * 65536);
    it.measured_rate  = spread(500 * 65536);
    it.start_angle    = spread(180 * 65536);
    it.time_step      = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                                     : 31'($urandom_range(1000, 70000));
    if (harsh) begin
      it.measured_angle = $urandom();
      it.measured_rate  = $urandom();
      it.time_step      = $urandom_range(0, 1) ? 31'($urandom())
                                               : 31'($urandom() >> $urandom_range(0, 30));
    end
    if (pick < 6) begin
      it.command        = 2'($urandom_range(0, 2));
      it.measured_angle = $urandom();
      it.measured_rate  = $urandom();
      it.time_step      = 31'($urandom());
      it.start_angle    = $urandom();
    end else if (pick < 9) begin
      it.command = CMD_REINIT;
    end else if (pick < 14) begin
      it.command = CMD_SET_ANGLE;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Reset values, masking of the unused top bit, and a write to the unmapped address.
  task automatic check_register_access();
    logic [31:0] unused_rdata;
    verify_noise_register(REG_ANGLE_NOISE);
    verify_noise_register(REG_BIAS_NOISE);
    verify_noise_register(REG_MEAS_NOISE);
    write_noise_register(REG_ANGLE_NOISE, 32'h8000_0000);
    write_noise_register(REG_BIAS_NOISE, 32'h7fff_ffff);
    write_noise_register(REG_MEAS_NOISE, 32'h5555_5555);
    apb_access(1'b1, UNMAPPED_ADDR, 32'hffff_ffff, unused_rdata);
    verify_noise_register(REG_ANGLE_NOISE);
    verify_noise_register(REG_BIAS_NOISE);
    verify_noise_register(REG_MEAS_NOISE);
    write_noise_register(REG_ANGLE_NOISE, 32'(ANGLE_NOISE_RST));
    write_noise_register(REG_BIAS_NOISE, 32'(BIAS_NOISE_RST));
    write_noise_register(REG_MEAS_NOISE, 32'(MEAS_NOISE_RST));
  endtask

  // Field extremes, every command including the unused code, a zero time step, and loads
  // of the angle that must keep the last rate.
  task automatic run_directed_items();
    send_item(make_item(CMD_UPDATE, 0, 0, 31'd0, 0));
    send_item(make_item(CMD_REINIT, 0, 0, 31'd0, 10 << 16));
    send_item(make_item(CMD_UPDATE, 12 << 16, 5 << 16, DT_1MS, 0));
    send_item(make_item(CMD_UPDATE, 12 << 16, 5 << 16, 31'd0, 0));
    send_item(make_item(CMD_SET_ANGLE, 0, ANGLE_MIN, DT_MAX, -(45 << 16)));
    send_item(make_item(CMD_UNUSED, ANGLE_MAX, ANGLE_MAX, DT_MAX, ANGLE_MAX));
    send_item(make_item(CMD_UPDATE, ANGLE_MAX, ANGLE_MIN, DT_1MS, 0));
    send_item(make_item(CMD_UPDATE, ANGLE_MIN, ANGLE_MAX, DT_MAX, 0));
    send_item(make_item(CMD_UPDATE, ANGLE_MAX, ANGLE_MAX, DT_MAX, 0));
    send_item(make_item(CMD_SET_ANGLE, 0, 0, 31'd0, ANGLE_MAX));
    send_item(make_item(CMD_UPDATE, ANGLE_MIN, ANGLE_MIN, DT_MAX, ANGLE_MIN));
    send_item(make_item(CMD_UNUSED, 0, 0, 31'd0, 0));
    send_item(make_item(CMD_REINIT, ANGLE_MAX, ANGLE_MAX, DT_MAX, ANGLE_MIN));
    // Large time steps with alternating extreme angles push the covariance into saturation.
    for (int i = 0; i < 6; i++)
      send_item(make_item(CMD_UPDATE, (i % 2) ? ANGLE_MIN : ANGLE_MAX, spread(32'h4000_0000),
                          DT_MAX, 0));
    send_item(make_item(CMD_REINIT, 0, 0, 31'd0, ANGLE_MAX));
    send_item(make_item(CMD_UPDATE, -1, -1, 31'd1, 0));
  endtask

  // A long stretch with no idling on either side.
  task automatic run_steady_stream(int count);
    steady = 1'b1;
    repeat (count) send_item(random_tilt_item(1'b0));
    steady = 1'b0;
  endtask

  // The sender stops part way and waits for every result before it carries on.
  task automatic run_drain_pause(int count);
    repeat (count) send_item(random_tilt_item(1'b0));
    drain_results();
    repeat (count) send_item(random_tilt_item(1'b0));
  endtask

  task automatic run_random_items(int count);
    repeat (count) send_item(random_tilt_item(1'b0));
  endtask

  // One noise setting: registers are written only once the block is idle, and each phase
  // starts from a fresh re-initialisation.
  task automatic run_noise_setting(logic [31:0] qa, logic [31:0] qb, logic [31:0] rm,
                                   bit harsh, int count);
    drain_results();
    write_noise_register(REG_ANGLE_NOISE, qa);
    write_noise_register(REG_BIAS_NOISE, qb);
    write_noise_register(REG_MEAS_NOISE, rm);
    send_item(make_item(CMD_REINIT, 0, 0, 31'd0, spread(180 * 65536)));
    repeat (count) send_item(random_tilt_item(harsh));
  endtask

  // The largest and smallest settings first, then random ones of varied magnitude, and
  // finally the reset values again.
  task automatic run_noise_sweep(int count);
    logic [31:0] rm;
    run_noise_setting(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, count);
    run_noise_setting(32'h0, 32'h0, 32'h1, 1'b1, count);
    for (int i = 0; i < 3; i++) begin
      rm = $urandom() >> $urandom_range(0, 24);
      if (rm[30:0] == 31'd0) rm = 32'h1;
      run_noise_setting($urandom() >> $urandom_range(0, 24),
                        $urandom() >> $urandom_range(0, 24), rm, i == 0, count);
    end
    run_noise_setting(32'(ANGLE_NOISE_RST), 32'(BIAS_NOISE_RST), 32'(MEAS_NOISE_RST),
                      1'b0, count);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    command        = CMD_UPDATE;
    measured_angle = '0;
    measured_rate  = '0;
    time_step      = '0;
    start_angle    = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    reset_tilt_model();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_register_access();
    run_directed_items();
    run_steady_stream(300);
    run_drain_pause(60);
    run_random_items(400);
    run_noise_sweep(190);

    // Let the last results arrive, then allow a little more than one update for anything
    // the block might still put out unasked.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/abkf_pkg.sv
rtl/abkf_alu.sv
rtl/angle_bias_kalman_filter.sv
rtl/abkf_checker.sv
tb/angle_bias_kalman_filter_test.sv
